FILE: rtl/dqdm_pkg.sv
// Shared types and constants for the deque with delete-after-match.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package dqdm_pkg;

    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_DEL_AFTER  = 3'd4,
        KIND_CLEAR      = 3'd5
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_NO_SUCC   = 3'd4
    } t_status;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH_FRONT,
        CELL_PUSH_BACK,
        CELL_POP_FRONT,
        CELL_POP_BACK,
        CELL_DELETE,
        CELL_CLEAR
    } t_cell_op;

    // control state
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [DATA_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] removed_value;
        logic [COUNT_W-1:0]       element_count;
    } t_resp;

    // broadcast control from the sequencer to the cells
    typedef struct packed {
        t_cell_op                 op;
        logic                     capture;
        logic signed [DATA_W-1:0] data;
    } t_cell_ctl;

    // match chain: a match lies in some earlier cell / the left neighbor is the first match
    typedef struct packed {
        logic seen;
        logic first;
    } t_seen;

    // removal chain: value taken out by a cell further left
    typedef struct packed {
        logic                     hit;
        logic signed [DATA_W-1:0] value;
    } t_rem;

endpackage

FILE: rtl/deque_with_delete_after_match.sv
// Top level of the deque with delete-after-match: sequencer, count, result register.
// Depends on dqdm_pkg and dqdm_cell (a row of CAPACITY cells).
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_ready    i_in_req   (t_req: kind, value)
//  result    out        o_out_valid / i_out_ready  o_out_resp (t_resp: status,
//                                                  removed_value, element_count)
//
// In the accept cycle every cell compares its entry with the key and registers
// the match; in the execute state, once the result register is free, the row
// shifts or updates in one step, the match and removal flags rippling through
// the row of cells. Reset clears the count and every valid bit directly; no
// clearing pass. A result waiting in the output register does not block
// acceptance; a second request then holds in execute until it drains.
`timescale 1ns / 1ps

module deque_with_delete_after_match
    import dqdm_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_req  i_in_req,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    output t_resp o_out_resp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    t_state                   r_state, n_state;
    logic [KIND_W-1:0]        r_kind;
    logic signed [DATA_W-1:0] r_value;
    logic [CNT_W-1:0]         r_count, n_count;
    logic                     r_out_valid;
    t_resp                    r_resp, n_resp;

    logic                     exec_go;
    logic                     cnt_full, cnt_empty;
    t_cell_ctl                cell_ctl;
    t_cell_op                 exec_op;

    logic signed [DATA_W-1:0] cell_value [CAPACITY];
    logic                     cell_valid [CAPACITY];
    t_seen                    seen_chain [CAPACITY+1];
    t_rem                     rem_chain  [CAPACITY+1];

    assign cnt_full  = (r_count == CNT_W'(CAPACITY));
    assign cnt_empty = (r_count == '0);
    assign exec_go   = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);

    // sequence: take a request, then execute once the result register is free
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // decode the request into a row operation, refusing illegal ones
    always_comb begin
        exec_op = CELL_HOLD;
        unique case (r_kind)
            KIND_PUSH_FRONT: exec_op = cnt_full  ? CELL_HOLD : CELL_PUSH_FRONT;
            KIND_PUSH_BACK:  exec_op = cnt_full  ? CELL_HOLD : CELL_PUSH_BACK;
            KIND_POP_FRONT:  exec_op = cnt_empty ? CELL_HOLD : CELL_POP_FRONT;
            KIND_POP_BACK:   exec_op = cnt_empty ? CELL_HOLD : CELL_POP_BACK;
            KIND_DEL_AFTER:  exec_op = cnt_empty ? CELL_HOLD : CELL_DELETE;
            KIND_CLEAR:      exec_op = CELL_CLEAR;
            default:         exec_op = CELL_HOLD;
        endcase
    end

    // broadcast to the row
    always_comb begin
        cell_ctl.capture = i_in_valid && o_in_ready;
        cell_ctl.op      = exec_go ? exec_op : CELL_HOLD;
        cell_ctl.data    = cell_ctl.capture ? i_in_req.value : r_value;
    end

    // chain ends
    assign seen_chain[0] = '{seen: 1'b0, first: 1'b0};
    assign rem_chain[0]  = '{hit: 1'b0, value: '0};

    // row of cells, front at cell 0
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_value, right_value;
        logic                     left_valid, right_valid;

        if (g == 0) begin : g_front
            assign left_value = r_value;
            assign left_valid = 1'b1;
        end else begin : g_inner_l
            assign left_value = cell_value[g-1];
            assign left_valid = cell_valid[g-1];
        end

        if (g == CAPACITY - 1) begin : g_back
            assign right_value = '0;
            assign right_valid = 1'b0;
        end else begin : g_inner_r
            assign right_value = cell_value[g+1];
            assign right_valid = cell_valid[g+1];
        end

        dqdm_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_left_value  (left_value),
            .i_left_valid  (left_valid),
            .i_right_value (right_value),
            .i_right_valid (right_valid),
            .i_seen        (seen_chain[g]),
            .o_seen        (seen_chain[g+1]),
            .i_rem         (rem_chain[g]),
            .o_rem         (rem_chain[g+1]),
            .o_value       (cell_value[g]),
            .o_valid       (cell_valid[g])
        );
    end

    // build the result and the next count
    always_comb begin
        n_count              = r_count;
        n_resp.status        = STAT_OK;
        n_resp.removed_value = '0;
        unique case (r_kind) inside
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                if (cnt_full) begin
                    n_resp.status = STAT_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            KIND_POP_FRONT: begin
                if (cnt_empty) begin
                    n_resp.status = STAT_EMPTY;
                end else begin
                    n_resp.removed_value = cell_value[0];
                    n_count              = r_count - 1'b1;
                end
            end
            KIND_POP_BACK: begin
                if (cnt_empty) begin
                    n_resp.status = STAT_EMPTY;
                end else begin
                    n_resp.removed_value = rem_chain[CAPACITY].value;
                    n_count              = r_count - 1'b1;
                end
            end
            KIND_DEL_AFTER: begin
                if (cnt_empty) begin
                    n_resp.status = STAT_EMPTY;
                end else if (!seen_chain[CAPACITY].seen) begin
                    n_resp.status = STAT_NOT_FOUND;
                end else if (!rem_chain[CAPACITY].hit) begin
                    n_resp.status = STAT_NO_SUCC;
                end else begin
                    n_resp.removed_value = rem_chain[CAPACITY].value;
                    n_count              = r_count - 1'b1;
                end
            end
            KIND_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        n_resp.element_count = COUNT_W'(n_count);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // latch the request and the result payload
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_kind  <= i_in_req.kind;
            r_value <= i_in_req.value;
        end
        if (exec_go) begin
            r_resp <= n_resp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_resp  = r_resp;

    // count never exceeds the row
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count beyond capacity");

    // front cell is occupied exactly when the count is nonzero
    a_front_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_valid[0] == (r_count != '0))
        else $error("front cell valid disagrees with count");

    // back cell is occupied exactly when the row is full
    a_back_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_valid[CAPACITY-1] == cnt_full)
        else $error("back cell valid disagrees with count");

    // an executed request always leaves a result behind
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_go |=> (o_out_valid && r_state == ST_IDLE))
        else $error("executed request produced no result");

endmodule

FILE: rtl/dqdm_cell.sv
// One storage cell of the deque row: value, valid bit and key-match flag.
// Depends on dqdm_pkg; instantiated once per entry by the top level.
`timescale 1ns / 1ps

module dqdm_cell
    import dqdm_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cell_ctl                i_ctl,
    input  logic signed [DATA_W-1:0] i_left_value,
    input  logic                     i_left_valid,
    input  logic signed [DATA_W-1:0] i_right_value,
    input  logic                     i_right_valid,
    input  t_seen                    i_seen,
    output t_seen                    o_seen,
    input  t_rem                     i_rem,
    output t_rem                     o_rem,
    output logic signed [DATA_W-1:0] o_value,
    output logic                     o_valid
);

    logic signed [DATA_W-1:0] r_value, n_value;
    logic                     r_valid, n_valid;
    logic                     r_match;
    logic                     take;

    // pass the match chain to the right neighbor
    always_comb begin
        o_seen.seen  = i_seen.seen | r_match;
        o_seen.first = r_match & ~i_seen.seen;
    end

    // this cell is the one taken out by pop back or delete-after-match
    always_comb begin
        take = 1'b0;
        if (i_ctl.op == CELL_DELETE) begin
            take = i_seen.first & r_valid;
        end else if (i_ctl.op == CELL_POP_BACK) begin
            take = r_valid & ~i_right_valid;
        end
        if (take) begin
            o_rem.hit   = 1'b1;
            o_rem.value = r_value;
        end else begin
            o_rem = i_rem;
        end
    end

    // next contents for the broadcast operation
    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        case (i_ctl.op)
            CELL_PUSH_FRONT: begin
                n_value = i_left_value;
                n_valid = i_left_valid;
            end
            CELL_PUSH_BACK: begin
                if (!r_valid && i_left_valid) begin
                    n_value = i_ctl.data;
                    n_valid = 1'b1;
                end
            end
            CELL_POP_FRONT: begin
                n_value = i_right_value;
                n_valid = i_right_valid;
            end
            CELL_POP_BACK: begin
                if (r_valid && !i_right_valid) begin
                    n_valid = 1'b0;
                end
            end
            CELL_DELETE: begin
                if (i_seen.seen) begin
                    n_value = i_right_value;
                    n_valid = i_right_valid;
                end
            end
            CELL_CLEAR: begin
                n_valid = 1'b0;
            end
            default: begin
                n_value = r_value;
                n_valid = r_valid;
            end
        endcase
    end

    // hold valid under reset, payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // store payload and latch the key compare when a request is taken
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        if (i_ctl.capture) begin
            r_match <= r_valid && (r_value == i_ctl.data);
        end
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule
